/* design/sfl_pkg.sv */
// shared types and constants for the slot free-list allocator
`timescale 1ns / 1ps

package sfl_pkg;

  // slot index width and the largest slot space the request format can name
  localparam int unsigned SLOT_W        = 8;
  localparam int unsigned SLOT_SPACE    = 256;
  localparam int unsigned COUNT_W       = 9;
  localparam int unsigned SLOTS_DEFAULT = 256;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // per-slot tag
  typedef enum logic [1:0] {
    TAG_NEVER = 2'd0,
    TAG_FREE  = 2'd1,
    TAG_ALLOC = 2'd2
  } tag_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_POP       = 3'd0,
    ST_BUMP      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FREED     = 3'd3,
    ST_REJECT    = 3'd4
  } status_t;

  // one slot entry: tag plus link to the next free slot
  typedef struct packed {
    tag_t              tag;
    logic              link_end;
    logic [SLOT_W-1:0] link;
  } entry_t;

  // write port of the slot store
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            entry;
  } store_wr_t;

endpackage

/* design/slot_free_list_bump_allocator_top.sv */
// top level of the slot allocator: free list plus bump index over one span
//
// channel | dir | handshake          | content
// s_*     | in  | s_tvalid/s_tready  | s_tdata: action[0], slot[8:1], zero fill
// m_*     | out | m_tvalid/m_tready  | m_tdata: result_slot[7:0], status[10:8],
//         |     |                    |          exhausted[11], zero fill
// cfg_*   | in  | cfg_wen            | cfg_wdata: span_limit
//
// each request first reads the slot store entry (head or requested slot),
// then is decided, writes the entry back and loads the result.
// the read-modify-write of the slot store sets this order.
// the result register frees the input side while a result waits; the decide
// cycle holds while the result register is still full and not taken.
// reset is synchronous; it clears all per-slot used bits at once, so every tag reads as never used (no clearing pass).
`timescale 1ns / 1ps

module slot_free_list_bump_allocator_top
  import sfl_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // action, slot
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // result_slot, status, exhausted
  input  logic                cfg_wen,
  input  logic [COUNT_W-1:0]  cfg_wdata  // span_limit
);

  localparam int unsigned DEPTH = (SLOTS < SLOT_SPACE) ? SLOTS : SLOT_SPACE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_LOOK
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] span_limit;
  logic               head_empty;
  logic [AW-1:0]      head_slot;
  logic [COUNT_W-1:0] bump_index;
  logic               req_action;
  logic [SLOT_W-1:0]  req_slot;

  logic               in_xfer;
  logic               out_free;
  logic               fire;
  logic [COUNT_W-1:0] eff_count;
  logic [SLOT_W-1:0]  rd_addr;
  entry_t             rd_entry;
  logic               rd_used;
  tag_t               rd_tag;
  store_wr_t          wr;

  logic               head_empty_next;
  logic [AW-1:0]      head_slot_next;
  logic [COUNT_W-1:0] bump_index_next;
  logic [SLOT_W-1:0]  res_slot;
  status_t            res_status;
  logic               exhausted_next;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == S_LOOK) && out_free;

  // effective slot count, capped at the store depth
  assign eff_count = (span_limit > DEPTH_CNT) ? DEPTH_CNT : span_limit;

  // read the free-list head for allocate, the named slot for free
  assign rd_addr = (s_tdata[0] == ACT_FREE) ? s_tdata[8:1] : SLOT_W'(head_slot);
  assign rd_tag  = rd_used ? rd_entry.tag : TAG_NEVER;

  sfl_slot_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_xfer),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_used  (rd_used),
    .wr       (wr)
  );

  // decide the request once the entry is back
  always_comb begin
    head_empty_next = head_empty;
    head_slot_next  = head_slot;
    bump_index_next = bump_index;
    res_slot        = '0;
    res_status      = ST_EXHAUSTED;
    wr.en           = 1'b0;
    wr.addr         = req_slot;
    wr.entry        = rd_entry;
    if (req_action == ACT_ALLOC) begin
      priority if (!head_empty) begin
        // pop the free-list head
        head_empty_next = rd_entry.link_end;
        head_slot_next  = rd_entry.link[AW-1:0];
        res_slot        = SLOT_W'(head_slot);
        res_status      = ST_POP;
        wr.en           = fire;
        wr.addr         = SLOT_W'(head_slot);
        wr.entry.tag    = TAG_ALLOC;
      end else if (bump_index < eff_count) begin
        // take the next never-used slot
        bump_index_next = bump_index + COUNT_W'(1);
        res_slot        = bump_index[SLOT_W-1:0];
        res_status      = ST_BUMP;
        wr.en           = fire;
        wr.addr         = bump_index[SLOT_W-1:0];
        wr.entry.tag    = TAG_ALLOC;
      end else begin
        res_status = ST_EXHAUSTED;
      end
    end else begin
      if (({1'b0, req_slot} < eff_count) && (rd_tag == TAG_ALLOC)) begin
        // push the slot on the free list
        head_empty_next   = 1'b0;
        head_slot_next    = req_slot[AW-1:0];
        res_slot          = req_slot;
        res_status        = ST_FREED;
        wr.en             = fire;
        wr.addr           = req_slot;
        wr.entry.tag      = TAG_FREE;
        wr.entry.link_end = head_empty;
        wr.entry.link     = SLOT_W'(head_slot);
      end else begin
        res_status = ST_REJECT;
      end
    end
    exhausted_next = head_empty_next && (bump_index_next >= eff_count);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_limit <= COUNT_RESET;
    end else if (cfg_wen) begin
      span_limit <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_action <= s_tdata[0];
      req_slot   <= s_tdata[8:1];
    end
  end

  // sequencer, allocator state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_empty <= 1'b1;
      head_slot  <= '0;
      bump_index <= '0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
    end else begin
      // result valid: set by a decision, cleared when taken
      priority if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            state      <= S_IDLE;
            head_empty <= head_empty_next;
            head_slot  <= head_slot_next;
            bump_index <= bump_index_next;
            m_tdata    <= {4'b0, exhausted_next, res_status, res_slot};
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the free-list head always names a free slot that was written
  a_head_is_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) && (req_action == ACT_ALLOC) && !head_empty
      |-> rd_used && (rd_entry.tag == TAG_FREE))
    else $error("free-list head does not hold a free slot");

  // bump index never passes the store depth
  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    bump_index <= DEPTH_CNT)
    else $error("bump index beyond store depth");

  // an exhausted result always reports the exhausted flag
  a_exhausted_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[10:8] == ST_EXHAUSTED) |-> m_tdata[11])
    else $error("exhausted status without exhausted flag");

  // a decision cycle never overlaps a new request
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_LOOK) && !s_tready)
    else $error("request accepted while another is in flight");
`endif

endmodule

/* design/sfl_slot_store.sv */
// slot store: synchronous memory of tags and links with per-slot used bits
`timescale 1ns / 1ps

module sfl_slot_store
  import sfl_pkg::*;
#(
  parameter int unsigned DEPTH = SLOT_SPACE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_addr,
  output entry_t            rd_entry,
  output logic              rd_used,
  input  store_wr_t         wr
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] used;

  // memory array, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry <= mem[rd_addr[AW-1:0]];
    end
  end

  // used bits: an entry never written reads as never used
  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= '0;
      rd_used <= 1'b0;
    end else begin
      if (wr.en) begin
        used[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_used <= used[rd_addr[AW-1:0]];
      end
    end
  end

endmodule

/* verif/slot_alloc_watch.sv */
// result checker for the slot allocator: tracks slot state, predicts and compares each result
`timescale 1ns / 1ps

module slot_alloc_watch
  import sfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [15:0]        s_tdata,   // action, slot
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [15:0]        m_tdata,   // result_slot, status, exhausted
  input  logic               cfg_wen,
  input  logic [COUNT_W-1:0] cfg_wdata, // span_limit
  output int                 mismatches,
  output int                 awaiting,
  output int                 results_seen,
  output logic [4:0]         status_seen
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              exhausted;
  } result_t;

  // shadow of the span: per-slot tag and free-list link, list head, bump index
  tag_t               slot_tags [SLOT_SPACE];
  logic [COUNT_W-1:0] next_free [SLOT_SPACE];
  logic [COUNT_W-1:0] head;       // bit 8 set: list empty
  logic [COUNT_W-1:0] bump;
  logic [COUNT_W-1:0] count_reg;
  result_t            pending_results [$];

  // slot count as the block uses it: capped at the slot space
  function automatic int usable_slots();
    return (count_reg > SLOT_SPACE) ? SLOT_SPACE : count_reg;
  endfunction

  // apply one request to the shadow state and return the result it gives
  function automatic result_t apply_request(input logic act, input logic [SLOT_W-1:0] req);
    result_t r;
    r = '0;
    if (act == ACT_ALLOC) begin
      if (!head[SLOT_W]) begin
        r.slot = head[SLOT_W-1:0];
        head = next_free[r.slot];
        slot_tags[r.slot] = TAG_ALLOC;
        r.status = ST_POP;
      end else if (bump < usable_slots()) begin
        r.slot = bump[SLOT_W-1:0];
        slot_tags[r.slot] = TAG_ALLOC;
        bump = bump + 1'b1;
        r.status = ST_BUMP;
      end else begin
        r.status = ST_EXHAUSTED;
      end
    end else if (req < usable_slots() && slot_tags[req] == TAG_ALLOC) begin
      next_free[req] = head;
      slot_tags[req] = TAG_FREE;
      head = {1'b0, req};
      r.slot = req;
      r.status = ST_FREED;
    end else begin
      r.status = ST_REJECT;
    end
    r.exhausted = head[SLOT_W] && (bump >= usable_slots());
    return r;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
  endtask

  // configuration first, then the result side, then the request side
  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (rst) begin
      for (int k = 0; k < SLOT_SPACE; k++) begin
        slot_tags[k] = TAG_NEVER;
        next_free[k] = '0;
      end
      head = 9'h100;
      bump = '0;
      count_reg = COUNT_RESET;
      pending_results.delete();
      mismatches = 0;
      results_seen = 0;
      status_seen = '0;
    end else begin
      if (cfg_wen) count_reg = cfg_wdata;
      if (m_tvalid && m_tready) begin
        got.slot = m_tdata[7:0];
        got.status = status_t'(m_tdata[10:8]);
        got.exhausted = m_tdata[11];
        results_seen++;
        if (m_tdata[10:8] <= ST_REJECT) status_seen[m_tdata[10:8]] = 1'b1;
        if (pending_results.size() == 0) begin
          report($sformatf("result with no request waiting: slot %0d status %0d exhausted %0b",
                           got.slot, got.status, got.exhausted));
        end else begin
          want = pending_results.pop_front();
          if (got.slot != want.slot || got.status != want.status ||
              got.exhausted != want.exhausted)
            report($sformatf({"result mismatch: expected slot %0d status %0d exhausted %0b,",
                              " got slot %0d status %0d exhausted %0b"},
                             want.slot, want.status, want.exhausted,
                             got.slot, got.status, got.exhausted));
        end
      end
      if (s_tvalid && s_tready) pending_results.push_back(apply_request(s_tdata[0], s_tdata[8:1]));
    end
    awaiting = pending_results.size();
  end

endmodule

/* verif/slot_free_list_bump_allocator_top_test.sv */
// testbench top for the slot allocator: directed and random requests, stalls and verdict
`timescale 1ns / 1ps

module slot_free_list_bump_allocator_top_test;
  import sfl_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 5000;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_GAP      = 17;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [15:0]        s_tdata = '0;  // action[0], slot[8:1]
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [15:0]        m_tdata;       // result_slot[7:0], status[10:8], exhausted[11]
  logic               cfg_wen = 1'b0;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  int         mismatches;
  int         awaiting;
  int         results_seen;
  logic [4:0] status_seen;

  int span = SLOT_SPACE;  // slot count in effect, for aiming frees
  int sent = 0;
  int hold_req = 0;       // long receiver hold-off, taken by the receiver process
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  slot_free_list_bump_allocator_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  slot_alloc_watch watch (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .awaiting     (awaiting),
    .results_seen (results_seen),
    .status_seen  (status_seen)
  );

  // one request transfer, after a random gap; valid stays high across back-to-back items
  task automatic send_req(input logic act, input logic [SLOT_W-1:0] slot);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'b0, slot, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // mostly aim frees inside the slot count, sometimes anywhere
  function automatic logic [SLOT_W-1:0] pick_victim();
    if (span > 0 && $urandom_range(0, 3) != 0) return SLOT_W'($urandom_range(0, span - 1));
    return SLOT_W'($urandom_range(0, SLOT_SPACE - 1));
  endfunction

  task automatic run_phase(input int n, input int alloc_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < alloc_pct)
        send_req(ACT_ALLOC, SLOT_W'($urandom_range(0, SLOT_SPACE - 1)));
      else
        send_req(ACT_FREE, pick_victim());
    end
  endtask

  // register write only once every result is back
  task automatic set_count(input logic [COUNT_W-1:0] value);
    s_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    span = (value > SLOT_SPACE) ? SLOT_SPACE : value;
  endtask

  // receiver: random stall before each transfer, or a long hold-off on request
  initial begin : receiver
    int gap;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_req > 0) begin
        gap = hold_req;
        hold_req = 0;
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end else begin
        if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        gap = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: bump up to a small count, exhaustion, rejects, list pops
    set_count(9'd3);
    send_req(ACT_FREE, 8'd0);      // never used slot
    send_req(ACT_ALLOC, 8'hFF);    // slot field ignored on allocate
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_ALLOC, 8'd0);     // last bump, exhausted flag rises
    send_req(ACT_ALLOC, 8'd0);     // nothing left
    send_req(ACT_FREE, 8'd255);    // out of range
    send_req(ACT_FREE, 8'd1);
    send_req(ACT_FREE, 8'd1);      // already free
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_FREE, 8'd0);
    send_req(ACT_FREE, 8'd2);
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_ALLOC, 8'd0);
    // zero count: no bumps, every free out of range
    set_count(9'd0);
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_FREE, 8'd0);
    set_count(9'd3);
    send_req(ACT_FREE, 8'd2);
    // count lowered under a listed slot: list still pops, bump stops
    set_count(9'd1);
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_FREE, 8'd2);
    // count above the slot space is capped
    set_count(9'd511);
    send_req(ACT_ALLOC, 8'd0);
    send_req(ACT_FREE, 8'd3);
    send_req(ACT_FREE, 8'd170);

    // random phases over several slot counts
    set_count(9'd0);
    run_phase(30, 50);
    set_count(9'd8);
    run_phase(150, 60);
    set_count(9'd40);
    run_phase(120, 55);
    set_count(9'd256);
    hold_req = 80;                 // back up the result side while requests keep coming
    run_phase(350, 80);
    set_count(9'd300);
    run_phase(80, 50);
    set_count(9'd1);
    run_phase(40, 50);

    // drain and settle
    s_tvalid <= 1'b0;
    for (int k = 0; k < DRAIN_CYCLES && awaiting != 0; k++) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d results over slot counts 0, 1, 3, 8, 40, 256, 300, 511",
             sent, results_seen);
    $display("status codes seen, reject down to pop: %b", status_seen);
    if (mismatches == 0 && awaiting == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
